// ----- hdl/kmcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Key matrix change detector package
// Field widths and default geometry shared by the change detector.
// ----------------------------------------------------------------------------
package kmcd_pkg;

   // Widths of the item fields on the ports.
   localparam int COLUMN_W    = 4;
   localparam int LEVELS_W    = 5;
   localparam int KEY_INDEX_W = 7;

   // Width used to form column + columns * row before truncation.
   localparam int KEY_CALC_W  = 16;

   // Default matrix geometry.
   localparam int DEF_COLUMNS = 14;
   localparam int DEF_ROWS    = 5;

endpackage

// ----- hdl/key_matrix_change_detector_top.sv -----
// ----------------------------------------------------------------------------
// Key matrix change detector
// Keeps the last row levels of every matrix column and, when reporting is
// enabled, reports one event per changed key, lowest row first.
// ----------------------------------------------------------------------------
// An input item names a column and its sampled row levels. On acceptance the
// stored levels of that column are compared and replaced in the same cycle, so
// every item with a column below COLUMNS, reported or not, updates state in
// arrival order. An item that changes n keys with reporting enabled emits n
// events, one per cycle unless the output stalls, from a work register into the
// output register; it holds the input until its last event goes out (n is at
// most ROWS), since the single event output is the limiting port. Items that
// cause no event (no change, reporting off, or a column of COLUMNS or more) are
// taken in every cycle while no item drains and never reach the work register.
// Reset clears all stored levels at once, so every key starts released.
module key_matrix_change_detector_top #(
   parameter int COLUMNS = kmcd_pkg::DEF_COLUMNS,
   parameter int ROWS    = kmcd_pkg::DEF_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [kmcd_pkg::COLUMN_W-1:0]    req_column,
   input  logic [kmcd_pkg::LEVELS_W-1:0]    req_row_levels,
   input  logic                             req_report_enable,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [kmcd_pkg::KEY_INDEX_W-1:0] rsp_key_index,
   output logic                             rsp_pressed,
   output logic                             rsp_last_event
);
   import kmcd_pkg::*;

   localparam int COL_IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int COL_EXT_W = (COL_IDX_W > COLUMN_W) ? COL_IDX_W : COLUMN_W;
   localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Stored levels per column.
   logic [ROWS-1:0]        levels_ff [COLUMNS];

   // Work register: the item whose events are being emitted.
   logic                   wk_valid_ff, wk_valid_in;
   logic [ROWS-1:0]        wk_mask_ff, wk_mask_in;
   logic [ROWS-1:0]        wk_levels_ff, wk_levels_in;
   logic [COL_IDX_W-1:0]   wk_col_ff, wk_col_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KEY_INDEX_W-1:0] rsp_key_ff, rsp_key_in;
   logic                   rsp_pressed_ff, rsp_pressed_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [COL_EXT_W-1:0]   col_ext;
   logic                   col_ok;
   logic [COL_IDX_W-1:0]   col_idx;
   logic [ROWS+LEVELS_W-1:0] lvl_wide;
   logic [ROWS-1:0]        new_levels;
   logic [ROWS-1:0]        changed;
   logic                   req_accept;
   logic                   out_free;
   logic                   emit;
   logic [ROWS-1:0]        mask_rest;
   logic                   emit_last;
   logic [ROW_IDX_W-1:0]   row_idx;
   logic [KEY_CALC_W-1:0]  key_calc;

   // Decode the incoming column and trim the row levels to the matrix height.
   assign col_ext    = COL_EXT_W'(req_column);
   assign col_ok     = {1'b0, col_ext} < (COL_EXT_W+1)'(COLUMNS);
   assign col_idx    = col_ext[COL_IDX_W-1:0];
   assign lvl_wide   = (ROWS+LEVELS_W)'(req_row_levels);
   assign new_levels = lvl_wide[ROWS-1:0];
   assign changed    = levels_ff[col_idx] ^ new_levels;

   // Handshake: the input waits only while an item in the work register is still draining.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = wk_valid_ff && out_free;
   assign mask_rest  = wk_mask_ff & (wk_mask_ff - ROWS'(1));
   assign emit_last  = (mask_rest == '0);
   assign req_stall  = wk_valid_ff && !(emit && emit_last);
   assign req_accept = req_valid && !req_stall;

   // Lowest pending row of the item in the work register.
   always_comb begin
      row_idx = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (wk_mask_ff[r]) begin
            row_idx = ROW_IDX_W'(r);
         end
      end
   end

   assign key_calc = KEY_CALC_W'(wk_col_ff) + KEY_CALC_W'(COLUMNS) * KEY_CALC_W'(row_idx);

   // Next state of the work register.
   always_comb begin
      wk_valid_in  = wk_valid_ff;
      wk_mask_in   = wk_mask_ff;
      wk_levels_in = wk_levels_ff;
      wk_col_in    = wk_col_ff;
      if (emit) begin
         wk_mask_in = mask_rest;
         if (emit_last) begin
            wk_valid_in = 1'b0;
         end
      end
      if (req_accept && col_ok && req_report_enable && (changed != '0)) begin
         wk_valid_in  = 1'b1;
         wk_mask_in   = changed;
         wk_levels_in = new_levels;
         wk_col_in    = col_idx;
      end
   end

   // Next state of the output register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_last_in    = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_key_in     = key_calc[KEY_INDEX_W-1:0];
            rsp_pressed_in = wk_levels_ff[row_idx];
            rsp_last_in    = emit_last;
         end
      end
   end

   // Control registers and the stored levels.
   always_ff @(posedge clock) begin
      if (reset) begin
         wk_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < COLUMNS; c++) begin
            levels_ff[c] <= '0;
         end
      end else begin
         wk_valid_ff  <= wk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept && col_ok) begin
            levels_ff[col_idx] <= new_levels;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wk_mask_ff     <= wk_mask_in;
      wk_levels_ff   <= wk_levels_in;
      wk_col_ff      <= wk_col_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_index  = rsp_key_ff;
   assign rsp_pressed    = rsp_pressed_ff;
   assign rsp_last_event = rsp_last_ff;

   // A busy work register always has at least one event left to emit.
   a_work_not_empty: assert property (@(posedge clock) disable iff (reset)
      wk_valid_ff |-> (wk_mask_ff != '0))
      else $error("work register busy with no pending rows");

   // The input is only held back while an item is draining.
   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      !wk_valid_ff |-> !req_stall)
      else $error("input stalled with an empty work register");

   // An event that is not the last keeps its item in the work register.
   a_drain_continues: assert property (@(posedge clock) disable iff (reset)
      (emit && !emit_last) |=> (wk_valid_ff && rsp_valid_ff && !rsp_last_ff))
      else $error("item left the work register before its last event");

   // Reset empties both the work and the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!wk_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
